>>> src/kpvd_pkg.sv
`timescale 1ns / 1ps

package kpvd_pkg;

  // Field widths.
  localparam int KEY_W   = 6;
  localparam int DEPTH_W = 17;
  localparam int VOL_W   = 21;
  localparam int GAIN_W  = 8;

  // Five-frame depth history per key.
  localparam int HIST_LEN = 5;
  localparam int SLOT_W   = 3;
  localparam logic [SLOT_W-1:0] SLOT_RESET = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_LAST  = 3'd4;

  // Sum of five samples and its magnitude.
  localparam int PAIR_W = DEPTH_W + 1;
  localparam int SUM_W  = DEPTH_W + 3;
  localparam int MAG_W  = SUM_W - 1;

  // Division by five: q = (mag * RECIP) >> RECIP_SHIFT, exact for mag below 2**22.
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP = 20'd838861;
  localparam int QPROD_W = MAG_W + RECIP_W;

  // Volume product: 18-bit difference times 9-bit non-negative gain.
  localparam int DIFF_W  = DEPTH_W + 1;
  localparam int VPROD_W = DIFF_W + GAIN_W + 1;
  localparam logic signed [VOL_W-1:0] VOL_MAX = 21'sh0FFFFF;
  localparam logic signed [VOL_W-1:0] VOL_MIN = 21'sh100000;

  // Comparison width for the key limit (key count up to 256).
  localparam int KEY_CMP_W = 9;
  localparam int NUM_KEYS_DEFAULT = 64;

  // Result queue.
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int OUT_PTR_W      = 3;
  localparam int OUT_CNT_W      = 4;

  // Configuration registers.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MUTE_LEVEL    = 2'd0,
    REG_SOUND_LEVEL   = 2'd1,
    REG_VELOCITY_GAIN = 2'd2
  } cfg_reg_t;

  localparam logic signed [DEPTH_W-1:0] MUTE_LEVEL_RESET  = 17'sd40;
  localparam logic signed [DEPTH_W-1:0] SOUND_LEVEL_RESET = 17'sd72;
  localparam logic [GAIN_W-1:0]         GAIN_RESET        = 8'd30;

  // Stream widths.
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  typedef logic signed [DEPTH_W-1:0] depth_t;
  typedef logic signed [VOL_W-1:0]   vol_t;
  typedef depth_t [HIST_LEN-1:0]     hist_row_t;

  typedef struct packed {
    logic              sounding;
    vol_t              volume;
    logic              note_on;
    depth_t            average_depth;
    logic [KEY_W-1:0]  key_out;
  } result_t;

endpackage

>>> src/key_press_velocity_detector_unit.sv
`timescale 1ns / 1ps

// Key press velocity detector. Each input word carries a key number and that
// key's depth for the current frame, in signed 1/16 mm units; each word gives
// exactly one result word, in order, with the key's new five-frame average
// depth, its stored volume and the note_on and sounding flags. The block takes
// one word per clock cycle while s_tready is high. The per-key history rows and
// the per-key average and volume live in two simple dual-port memories with a
// registered read, each updated by a read-modify-write in one stage with one
// word of forwarding, so repeated words for the same key in consecutive cycles
// are handled at full rate. Results pass through an eight-word queue; s_tready
// drops only when eight words are in flight or queued, so the input keeps
// flowing while m_tready is low for short spells. Both memories read as zero
// after reset through per-key valid flags, so no clearing pass is needed.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// do so only while the block is idle, which the block does not enforce. Keys at
// or above NUM_KEYS leave all per-key state untouched and return zeros beside key_out.
module key_press_velocity_detector_unit
  import kpvd_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // key_number[5:0], depth_sample[22:6], zeros
  input  logic                  s_tlast,   // frame_end
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // key_out[5:0], average_depth[22:6],
                                           // volume[43:23], zeros
  output logic [M_TUSER_W-1:0]  m_tuser,   // note_on[0], sounding[1]
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KEY_CMP_W-1:0] KeyLimit = KEY_CMP_W'(NUM_KEYS);

  // Configuration registers.
  depth_t             mute_level;
  depth_t             sound_level;
  logic [GAIN_W-1:0]  velocity_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      mute_level    <= MUTE_LEVEL_RESET;
      sound_level   <= SOUND_LEVEL_RESET;
      velocity_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MUTE_LEVEL:    mute_level    <= cfg_data;
        REG_SOUND_LEVEL:   sound_level   <= cfg_data;
        REG_VELOCITY_GAIN: velocity_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side.
  logic [KEY_W-1:0] in_key;
  depth_t           in_depth;
  logic             in_range;
  logic [KW-1:0]    in_idx;
  logic             accept;
  logic [OUT_CNT_W-1:0] occ;
  logic             pop;

  assign in_key   = s_tdata[KEY_W-1:0];
  assign in_depth = s_tdata[KEY_W+DEPTH_W-1:KEY_W];
  assign in_range = {{(KEY_CMP_W-KEY_W){1'b0}}, in_key} < KeyLimit;
  assign in_idx   = KW'({{KW{1'b0}}, in_key});
  assign s_tready = occ < OUT_CNT_W'(OUT_FIFO_DEPTH);
  assign accept   = s_tvalid && s_tready;

  // The history slot is shared by all keys and moves on after the frame's last word.
  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_RESET;
    end else if (accept && s_tlast) begin
      slot <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    end
  end

  // Occupancy counts words in the pipeline plus words in the result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OUT_CNT_W'(accept) - OUT_CNT_W'(pop);
    end
  end

  // Stage valid flags.
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: history row read-modify-write.
  hist_row_t        hist_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] hist_valid;
  hist_row_t        hist_rd;
  logic             hist_rd_valid;
  logic [KEY_W-1:0] k1;
  logic             r1;
  depth_t           d1;
  logic [SLOT_W-1:0] slot1;
  logic [KW-1:0]    idx1;
  hist_row_t        old_row;
  hist_row_t        new_row;
  logic             hist_we;

  // Forwarding of the row written in the previous cycle.
  logic             hf_valid;
  logic [KEY_W-1:0] hf_key;
  hist_row_t        hf_row;

  always_ff @(posedge clk) begin
    if (accept) begin
      k1    <= in_key;
      r1    <= in_range;
      d1    <= in_depth;
      slot1 <= slot;
    end
  end

  assign idx1    = KW'({{KW{1'b0}}, k1});
  assign hist_we = v1 && r1;

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      hist_rd       <= hist_mem[in_idx];
      hist_rd_valid <= hist_valid[in_idx];
    end
    if (hist_we) begin
      hist_mem[idx1] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      hf_valid   <= 1'b0;
    end else begin
      if (hist_we) begin
        hist_valid[idx1] <= 1'b1;
      end
      hf_valid <= hist_we;
    end
  end

  always_ff @(posedge clk) begin
    hf_key <= k1;
    hf_row <= new_row;
  end

  always_comb begin
    if (hf_valid && hf_key == k1) begin
      old_row = hf_row;
    end else if (hist_rd_valid) begin
      old_row = hist_rd;
    end else begin
      old_row = '0;
    end
  end

  for (genvar i = 0; i < HIST_LEN; i++) begin : g_lane
    assign new_row[i] = (slot1 == SLOT_W'(i)) ? d1 : old_row[i];
  end

  // Partial sums for stage 2.
  logic signed [PAIR_W-1:0]  s01, s23;
  depth_t                    e2;
  logic [KEY_W-1:0]          k2;
  logic                      r2;

  always_ff @(posedge clk) begin
    s01 <= PAIR_W'(new_row[0]) + PAIR_W'(new_row[1]);
    s23 <= PAIR_W'(new_row[2]) + PAIR_W'(new_row[3]);
    e2  <= new_row[4];
    k2  <= k1;
    r2  <= r1;
  end

  // Stage 2: full sum and its magnitude.
  logic signed [SUM_W-1:0] sum2;
  logic [SUM_W-1:0]        abs2;
  logic [MAG_W-1:0]        mag3;
  logic                    neg3;
  logic [KEY_W-1:0]        k3;
  logic                    r3;

  assign sum2 = SUM_W'(s01) + SUM_W'(s23) + SUM_W'(e2);
  assign abs2 = sum2[SUM_W-1] ? SUM_W'(-sum2) : SUM_W'(sum2);

  always_ff @(posedge clk) begin
    mag3 <= abs2[MAG_W-1:0];
    neg3 <= sum2[SUM_W-1];
    k3   <= k2;
    r3   <= r2;
  end

  // Stage 3: multiply by the reciprocal of five.
  logic [QPROD_W-1:0] qprod4;
  logic               neg4;
  logic [KEY_W-1:0]   k4;
  logic               r4;

  always_ff @(posedge clk) begin
    qprod4 <= QPROD_W'(mag3) * QPROD_W'(RECIP);
    neg4   <= neg3;
    k4     <= k3;
    r4     <= r3;
  end

  // Stage 4: restore the sign (truncation towards zero) and read the key's
  // average and volume.
  logic [DEPTH_W-1:0] q4;
  depth_t             avg4;
  logic [KW-1:0]      idx4;

  assign q4   = qprod4[RECIP_SHIFT+DEPTH_W-1:RECIP_SHIFT];
  assign avg4 = neg4 ? depth_t'(-q4) : depth_t'(q4);
  assign idx4 = KW'({{KW{1'b0}}, k4});

  depth_t             avg5;
  logic [KEY_W-1:0]   k5;
  logic               r5;

  always_ff @(posedge clk) begin
    avg5 <= avg4;
    k5   <= k4;
    r5   <= r4;
  end

  // Stage 5: average and volume read-modify-write.
  depth_t           avg_mem [NUM_KEYS];
  vol_t             vol_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] av_valid;
  depth_t           avg_rd;
  vol_t             vol_rd;
  logic             av_rd_valid;
  logic [KW-1:0]    idx5;
  logic             av_we;

  logic             af_valid;
  logic [KEY_W-1:0] af_key;
  depth_t           af_avg;
  vol_t             af_vol;

  depth_t                    prev_avg;
  vol_t                      old_vol;
  vol_t                      muted_vol;
  logic                      trigger;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [VPROD_W-1:0] vprod;
  vol_t                      sat_vol;
  vol_t                      new_vol;

  assign idx5  = KW'({{KW{1'b0}}, k5});
  assign av_we = v5 && r5;

  always_ff @(posedge clk) begin
    if (v4 && r4) begin
      avg_rd      <= avg_mem[idx4];
      vol_rd      <= vol_mem[idx4];
      av_rd_valid <= av_valid[idx4];
    end
    if (av_we) begin
      avg_mem[idx5] <= avg5;
      vol_mem[idx5] <= new_vol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av_valid <= '0;
      af_valid <= 1'b0;
    end else begin
      if (av_we) begin
        av_valid[idx5] <= 1'b1;
      end
      af_valid <= av_we;
    end
  end

  always_ff @(posedge clk) begin
    af_key <= k5;
    af_avg <= avg5;
    af_vol <= new_vol;
  end

  always_comb begin
    if (af_valid && af_key == k5) begin
      prev_avg = af_avg;
      old_vol  = af_vol;
    end else if (av_rd_valid) begin
      prev_avg = avg_rd;
      old_vol  = vol_rd;
    end else begin
      prev_avg = '0;
      old_vol  = '0;
    end
  end

  // Muting comes first, so a key both below mute and above sound re-triggers.
  assign muted_vol = (avg5 < mute_level) ? '0 : old_vol;
  assign trigger   = (avg5 > sound_level) && (muted_vol == '0);
  assign diff      = DIFF_W'(avg5) - DIFF_W'(prev_avg);
  assign vprod     = diff * $signed({1'b0, velocity_gain});

  always_comb begin
    if (&vprod[VPROD_W-1:VOL_W-1] || ~|vprod[VPROD_W-1:VOL_W-1]) begin
      sat_vol = vprod[VOL_W-1:0];
    end else if (vprod[VPROD_W-1]) begin
      sat_vol = VOL_MIN;
    end else begin
      sat_vol = VOL_MAX;
    end
  end

  assign new_vol = trigger ? sat_vol : muted_vol;

  result_t res5;

  always_comb begin
    res5.key_out = k5;
    if (r5) begin
      res5.average_depth = avg5;
      res5.note_on       = trigger;
      res5.volume        = new_vol;
      res5.sounding      = !new_vol[VOL_W-1] && (new_vol != '0);
    end else begin
      res5.average_depth = '0;
      res5.note_on       = 1'b0;
      res5.volume        = '0;
      res5.sounding      = 1'b0;
    end
  end

  // Result queue; occupancy accounting guarantees it never overflows.
  result_t              fifo_mem [OUT_FIFO_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] fcount;
  result_t              head;

  assign m_tvalid = fcount != '0;
  assign pop      = m_tvalid && m_tready;
  assign head     = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (v5) begin
      fifo_mem[wr_ptr] <= res5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcount <= '0;
    end else begin
      if (v5) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fcount <= fcount + OUT_CNT_W'(v5) - OUT_CNT_W'(pop);
    end
  end

  assign m_tdata = {{(M_TDATA_W-KEY_W-DEPTH_W-VOL_W){1'b0}},
                    head.volume, head.average_depth, head.key_out};
  assign m_tuser = {head.sounding, head.note_on};

endmodule
